>>> src/jtc_pkg.sv
// Shared types, field widths and codes of the journal transaction controller.
package jtc_pkg;

  // Field widths
  localparam int unsigned BLK_W  = 24;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CAP_W  = 6;
  localparam int unsigned DEV_W  = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned REG_W  = 2;

  // Parameter defaults
  localparam int unsigned LOG_ENTRIES_DEFAULT          = 30;
  localparam int unsigned BLOCKS_PER_OPERATION_DEFAULT = 10;

  // Register reset values
  localparam logic [BLK_W-1:0] LOG_START_RESET = 24'd2;
  localparam logic [CAP_W-1:0] LOG_CAP_RESET   = 6'd30;
  localparam logic [DEV_W-1:0] DEVICE_RESET    = 8'd1;

  // Register indexes
  localparam logic [REG_W-1:0] REG_LOG_START = 2'd0;
  localparam logic [REG_W-1:0] REG_LOG_CAP   = 2'd1;
  localparam logic [REG_W-1:0] REG_DEVICE    = 2'd2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  // Result commands
  localparam logic [CMD_W-1:0] CMD_STATUS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOGCOPY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HEADER  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INSTALL = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [ST_W-1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  block_number;
  } in_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] source_block;
    logic [BLK_W-1:0] target_block;
    logic [DEV_W-1:0] device;
    logic [CNT_W-1:0] header_count;
    logic [ST_W-1:0]  status;
    logic             newly_added;
    logic             last;
  } out_t;

endpackage

>>> src/journal_transaction_controller.sv
// Journal transaction controller: request sequencer, commit emitter and result register.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------------
//  request   | start, busy, item_i                     | taken when start & !busy
//  result    | result_valid_o, result_o                | no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i         | written when cfg_we_i
//
// A request that needs no table walk or commit shows its status result in the cycle after it is taken.
// A log write that hits a non-empty table walks the table one entry per cycle through
// the single compare unit before the status result.
// A commit of n entries emits 2n+2 commands and the status, one per cycle, sequenced with
// one shared 24-bit address adder. busy is high while walking or emitting.
// Reset clears the counters and loads the config defaults; the table keeps its contents.
// Results cannot be held off by the receiver.
module journal_transaction_controller #(
  parameter int unsigned LOG_ENTRIES          = jtc_pkg::LOG_ENTRIES_DEFAULT,
  parameter int unsigned BLOCKS_PER_OPERATION = jtc_pkg::BLOCKS_PER_OPERATION_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  jtc_pkg::in_t              item_i,
  output logic                      result_valid_o,
  output jtc_pkg::out_t             result_o,
  input  logic                      cfg_we_i,
  input  logic [jtc_pkg::REG_W-1:0] cfg_idx_i,
  input  logic [jtc_pkg::BLK_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W  = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int unsigned NEED_W = 12;
  localparam int unsigned CNT_W  = jtc_pkg::CNT_W;
  localparam int unsigned BLK_W  = jtc_pkg::BLK_W;
  localparam int unsigned CAP_W  = jtc_pkg::CAP_W;
  localparam int unsigned DEV_W  = jtc_pkg::DEV_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_LCOPY  = 3'd2;
  localparam logic [2:0] S_HDR1   = 3'd3;
  localparam logic [2:0] S_INST   = 3'd4;
  localparam logic [2:0] S_HDR0   = 3'd5;
  localparam logic [2:0] S_STAT   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] open_q, open_d;
  logic [BLK_W-1:0] key_q, key_d;
  logic [BLK_W-1:0] lsb_q;
  logic [CAP_W-1:0] cap_q;
  logic [DEV_W-1:0] dev_q;
  logic             valid_q, valid_d;
  jtc_pkg::out_t    res_q, res_d;

  logic             we;
  logic [BLK_W-1:0] wdata;
  logic [BLK_W-1:0] rdata;
  logic             match;
  logic [BLK_W-1:0] addr_sum;
  logic [CNT_W-1:0] idx_next;
  logic             idx_at_end;
  logic [NEED_W-1:0] need;
  logic             begin_refused;
  logic             write_full;

  // Entry table; the next walk index is read so the entry lands with idx_q
  jtc_entry_store #(
    .WIDTH (BLK_W),
    .DEPTH (LOG_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  // Single compare unit: walked entry against the search key
  assign match = (rdata == key_q);

  // Shared log address adder: header block + 1 + walk index
  assign idx_next   = CNT_W'(idx_q) + CNT_W'(1);
  assign idx_at_end = (idx_next == count_q);
  assign addr_sum   = lsb_q + BLK_W'(idx_next);

  // Admission and room checks
  assign need = NEED_W'(count_q)
              + (NEED_W'(open_q) + NEED_W'(1)) * NEED_W'(BLOCKS_PER_OPERATION);
  assign begin_refused = (&open_q) || (need > NEED_W'(cap_q));
  assign write_full    = (count_q >= CNT_W'(LOG_ENTRIES))
                      || (({1'b0, count_q} + CAP_W'(1)) >= cap_q);

  assign wdata = (state_q == S_IDLE) ? item_i.block_number : key_q;

  // Sequence requests, table walks and commit commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    open_d  = open_q;
    key_d   = key_q;
    valid_d = 1'b0;
    res_d   = '0;
    we      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          valid_d        = 1'b1;
          res_d.command  = jtc_pkg::CMD_STATUS;
          res_d.last     = 1'b1;
          case (item_i.kind)
            jtc_pkg::KIND_BEGIN: begin
              if (begin_refused) begin
                res_d.status = jtc_pkg::ST_REFUSED;
              end else begin
                open_d = open_q + CNT_W'(1);
              end
            end
            jtc_pkg::KIND_END: begin
              if (open_q == '0) begin
                res_d.status = jtc_pkg::ST_ERROR;
              end else begin
                open_d = open_q - CNT_W'(1);
                if ((open_q == CNT_W'(1)) && (count_q != '0)) begin
                  valid_d = 1'b0;
                  res_d   = '0;
                  idx_d   = '0;
                  state_d = S_LCOPY;
                end
              end
            end
            jtc_pkg::KIND_WRITE: begin
              if (write_full) begin
                res_d.status = jtc_pkg::ST_REFUSED;
              end else if (open_q == '0) begin
                res_d.status = jtc_pkg::ST_ERROR;
              end else if (count_q == '0) begin
                // Empty table: append at once
                we                = 1'b1;
                count_d           = count_q + CNT_W'(1);
                res_d.newly_added = 1'b1;
              end else begin
                valid_d = 1'b0;
                res_d   = '0;
                key_d   = item_i.block_number;
                idx_d   = '0;
                state_d = S_SEARCH;
              end
            end
            default: begin
              res_d.status = jtc_pkg::ST_ERROR;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (match) begin
          valid_d       = 1'b1;
          res_d.command = jtc_pkg::CMD_STATUS;
          res_d.last    = 1'b1;
          state_d       = S_IDLE;
        end else if (idx_at_end) begin
          // Not found: append the key
          we                = 1'b1;
          count_d           = count_q + CNT_W'(1);
          valid_d           = 1'b1;
          res_d.command     = jtc_pkg::CMD_STATUS;
          res_d.newly_added = 1'b1;
          res_d.last        = 1'b1;
          state_d           = S_IDLE;
        end else begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      S_LCOPY: begin
        valid_d            = 1'b1;
        res_d.command      = jtc_pkg::CMD_LOGCOPY;
        res_d.source_block = rdata;
        res_d.target_block = addr_sum;
        res_d.device       = dev_q;
        if (idx_at_end) begin
          idx_d   = '0;
          state_d = S_HDR1;
        end else begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      S_HDR1: begin
        valid_d            = 1'b1;
        res_d.command      = jtc_pkg::CMD_HEADER;
        res_d.target_block = lsb_q;
        res_d.device       = dev_q;
        res_d.header_count = count_q;
        state_d            = S_INST;
      end
      S_INST: begin
        valid_d            = 1'b1;
        res_d.command      = jtc_pkg::CMD_INSTALL;
        res_d.source_block = addr_sum;
        res_d.target_block = rdata;
        res_d.device       = dev_q;
        if (idx_at_end) begin
          idx_d   = '0;
          state_d = S_HDR0;
        end else begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      S_HDR0: begin
        valid_d            = 1'b1;
        res_d.command      = jtc_pkg::CMD_HEADER;
        res_d.target_block = lsb_q;
        res_d.device       = dev_q;
        count_d            = '0;
        state_d            = S_STAT;
      end
      S_STAT: begin
        valid_d       = 1'b1;
        res_d.command = jtc_pkg::CMD_STATUS;
        res_d.last    = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      open_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      open_q  <= open_d;
      valid_q <= valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
  end

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsb_q <= jtc_pkg::LOG_START_RESET;
      cap_q <= jtc_pkg::LOG_CAP_RESET;
      dev_q <= jtc_pkg::DEVICE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jtc_pkg::REG_LOG_START: lsb_q <= cfg_data_i;
        jtc_pkg::REG_LOG_CAP:   cap_q <= cfg_data_i[CAP_W-1:0];
        jtc_pkg::REG_DEVICE:    dev_q <= cfg_data_i[DEV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The closing status item always leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> !busy)
    else $error("status item emitted while sequencer busy");

  // Commands carry an ok status and never close the run
  a_cmd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.command != jtc_pkg::CMD_STATUS))
      |-> ((result_o.status == jtc_pkg::ST_OK) && !result_o.last))
    else $error("command item with status or last set");

  // Table fill never passes its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LOG_ENTRIES))
    else $error("entry count beyond table depth");

  // Commit only runs with no open operation
  a_commit_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LCOPY) || (state_q == S_HDR1) || (state_q == S_INST)
      || (state_q == S_HDR0)) |-> (open_q == '0))
    else $error("commit with open operations");

  // A commit of a non-empty table emits a cleared header after its installs
  a_hdr0_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HDR0) |=> (result_valid_o && (result_o.command == jtc_pkg::CMD_HEADER)
      && (result_o.header_count == '0)))
    else $error("closing header write missing");

endmodule

>>> src/jtc_entry_store.sv
// Generic RAM with one write port and a registered read port.
module jtc_entry_store #(
  parameter int unsigned WIDTH = jtc_pkg::BLK_W,
  parameter int unsigned DEPTH = jtc_pkg::LOG_ENTRIES_DEFAULT,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> bench/tb_journal_transaction_controller.sv
// Self-checking testbench for the journal transaction controller.
module tb_journal_transaction_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import jtc_pkg::*;

  localparam int unsigned LOG_ENTRIES   = LOG_ENTRIES_DEFAULT;
  localparam int unsigned BLOCKS_PER_OP = BLOCKS_PER_OPERATION_DEFAULT;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          TAIL_CYCLES   = 40;

  // Codes the package leaves unnamed
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [REG_W-1:0]  REG_UNUSED   = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  in_t               item_i;
  logic              result_valid_o;
  out_t              result_o;
  logic              cfg_we_i;
  logic [REG_W-1:0]  cfg_idx_i;
  logic [BLK_W-1:0]  cfg_data_i;

  // Shadow registers and journal state
  logic [BLK_W-1:0]  shadow_log_start;
  logic [CAP_W-1:0]  shadow_capacity;
  logic [DEV_W-1:0]  shadow_device;
  logic [BLK_W-1:0]  table_blocks [LOG_ENTRIES];
  int                table_count;
  int                open_ops;
  logic [ST_W-1:0]   last_status;

  out_t              due_results [$];
  logic [BLK_W-1:0]  block_pool [8];
  int                ok_items;
  int                calm_left;
  int                mismatches;
  int                quiet_cycles;

  journal_transaction_controller #(
    .LOG_ENTRIES          (LOG_ENTRIES),
    .BLOCKS_PER_OPERATION (BLOCKS_PER_OP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_t make_result(input logic [CMD_W-1:0] cmd,
                                       input logic [BLK_W-1:0] src,
                                       input logic [BLK_W-1:0] tgt,
                                       input logic [DEV_W-1:0] dev,
                                       input logic [CNT_W-1:0] cnt,
                                       input logic [ST_W-1:0] st,
                                       input logic added,
                                       input logic fin);
    out_t r;
    r.command      = cmd;
    r.source_block = src;
    r.target_block = tgt;
    r.device       = dev;
    r.header_count = cnt;
    r.status       = st;
    r.newly_added  = added;
    r.last         = fin;
    return r;
  endfunction

  // Advance the journal by one request and queue the results it causes
  task automatic journal_apply(input in_t req);
    int need;
    bit found;
    logic [ST_W-1:0] st;
    logic added;
    st    = ST_OK;
    added = 1'b0;
    case (req.kind)
      KIND_BEGIN: begin
        need = table_count + (open_ops + 1) * BLOCKS_PER_OP;
        if (open_ops >= 31 || need > int'(shadow_capacity)) st = ST_REFUSED;
        else open_ops++;
      end
      KIND_END: begin
        if (open_ops == 0) begin
          st = ST_ERROR;
        end else begin
          open_ops--;
          // Group commit: log copies, header, installs, cleared header
          if (open_ops == 0 && table_count > 0) begin
            for (int i = 0; i < table_count; i++)
              due_results.push_back(make_result(CMD_LOGCOPY, table_blocks[i],
                  shadow_log_start + BLK_W'(i + 1), shadow_device, '0, ST_OK, 1'b0, 1'b0));
            due_results.push_back(make_result(CMD_HEADER, '0, shadow_log_start,
                shadow_device, CNT_W'(table_count), ST_OK, 1'b0, 1'b0));
            for (int i = 0; i < table_count; i++)
              due_results.push_back(make_result(CMD_INSTALL,
                  shadow_log_start + BLK_W'(i + 1), table_blocks[i], shadow_device, '0,
                  ST_OK, 1'b0, 1'b0));
            due_results.push_back(make_result(CMD_HEADER, '0, shadow_log_start,
                shadow_device, '0, ST_OK, 1'b0, 1'b0));
            table_count = 0;
          end
        end
      end
      KIND_WRITE: begin
        if (table_count >= int'(LOG_ENTRIES) || table_count + 1 >= int'(shadow_capacity)) begin
          st = ST_REFUSED;
        end else if (open_ops == 0) begin
          st = ST_ERROR;
        end else begin
          // Absorb a block that is already in the table
          found = 1'b0;
          for (int i = 0; i < table_count; i++)
            if (table_blocks[i] == req.block_number) found = 1'b1;
          if (!found) begin
            table_blocks[table_count] = req.block_number;
            table_count++;
            added = 1'b1;
          end
        end
      end
      default: st = ST_ERROR;
    endcase
    due_results.push_back(make_result(CMD_STATUS, '0, '0, '0, '0, st, added, 1'b1));
    last_status = st;
  endtask

  // Present one item and hold it until the block takes it
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BLK_W-1:0] blk);
    in_t req;
    req.kind         = kind;
    req.block_number = blk;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= req;
    do @(posedge clk_i); while (busy !== 1'b0);
    journal_apply(req);
    if (last_status == ST_OK) ok_items++;
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Drop start and wait until every queued result has come out
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [REG_W-1:0] idx, input logic [BLK_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_LOG_START: shadow_log_start = data;
      REG_LOG_CAP:   shadow_capacity  = data[CAP_W-1:0];
      REG_DEVICE:    shadow_device    = data[DEV_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [BLK_W-1:0] log_start, input int capacity,
                           input int dev);
    write_register(REG_LOG_START, log_start);
    write_register(REG_LOG_CAP, BLK_W'(capacity));
    write_register(REG_DEVICE, BLK_W'(dev));
  endtask

  // Mostly reuse a few blocks so absorption happens, sometimes any block
  function automatic logic [BLK_W-1:0] pick_block();
    if ($urandom_range(0, 3) == 0) return BLK_W'($urandom());
    return block_pool[$urandom_range(0, 7)];
  endfunction

  task automatic refresh_pool();
    foreach (block_pool[i]) block_pool[i] = BLK_W'($urandom());
    if ($urandom_range(0, 1) == 0) block_pool[0] = '0;
    if ($urandom_range(0, 1) == 0) block_pool[1] = '1;
  endtask

  // Idle the sender in random bursts, with calm stretches and full drains
  task automatic maybe_idle(input bit gaps);
    int pick;
    if (!gaps) return;
    if (calm_left > 0) begin
      calm_left--;
      return;
    end
    pick = $urandom_range(0, 29);
    if (pick < 6) pause_sender($urandom_range(1, 19));
    else if (pick == 6) drain_results();
    else if (pick == 7) calm_left = $urandom_range(5, 15);
  endtask

  // Mostly well-formed operations with random content, the rest noise
  task automatic run_traffic(input int target, input bit gaps);
    int base;
    int writes;
    base = ok_items;
    while (ok_items - base < target) begin
      if ($urandom_range(0, 9) < 7) begin
        maybe_idle(gaps);
        send_request(KIND_BEGIN, BLK_W'($urandom()));
        writes = $urandom_range(0, 6);
        repeat (writes) begin
          maybe_idle(gaps);
          if ($urandom_range(0, 5) == 0) send_request(KIND_BEGIN, BLK_W'($urandom()));
          else send_request(KIND_WRITE, pick_block());
        end
        while (open_ops > 0) begin
          maybe_idle(gaps);
          send_request(KIND_END, BLK_W'($urandom()));
        end
      end else begin
        maybe_idle(gaps);
        send_request(KIND_W'($urandom_range(0, 3)), BLK_W'($urandom()));
      end
    end
  endtask

  // Requests that must fail with nothing open
  task automatic test_idle_errors();
    send_request(KIND_END, '0);
    send_request(KIND_WRITE, 24'h00_1234);
    send_request(KIND_UNKNOWN, '1);
    drain_results();
  endtask

  // Admission up to the reservation limit, absorption, nested ends, empty commit
  task automatic test_admission_and_absorption();
    repeat (4) send_request(KIND_BEGIN, '0);
    send_request(KIND_WRITE, '0);
    send_request(KIND_WRITE, '1);
    send_request(KIND_WRITE, '0);
    repeat (3) send_request(KIND_END, '0);
    send_request(KIND_BEGIN, '1);
    send_request(KIND_END, '1);
    drain_results();
  endtask

  // Register extremes, log space refusals, address wrap, unused register index
  task automatic test_log_space_limits();
    configure('1, 2, 255);
    send_request(KIND_BEGIN, '0);
    drain_results();
    write_register(REG_LOG_CAP, BLK_W'(12));
    send_request(KIND_BEGIN, '0);
    drain_results();
    write_register(REG_LOG_CAP, BLK_W'(3));
    send_request(KIND_WRITE, 24'hAA_5555);
    send_request(KIND_WRITE, 24'h55_AAAA);
    send_request(KIND_WRITE, 24'h0F_0F0F);
    send_request(KIND_BEGIN, '0);
    send_request(KIND_END, '0);
    drain_results();
    write_register(REG_UNUSED, '1);
    configure('0, 32, 0);
    send_request(KIND_BEGIN, '0);
    send_request(KIND_WRITE, BLK_W'($urandom()));
    send_request(KIND_END, '0);
    drain_results();
  endtask

  // Fill the whole table, hit the entry limit, then the longest commit
  task automatic test_full_table();
    configure(BLK_W'($urandom()), 32, $urandom_range(0, 255));
    send_request(KIND_BEGIN, '0);
    repeat (LOG_ENTRIES + 1) send_request(KIND_WRITE, BLK_W'($urandom()));
    send_request(KIND_WRITE, table_blocks[0]);
    send_request(KIND_END, '0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: configure(24'hFF_FFF0, 32, 255);
        1: configure('0, 10, 0);
        default: configure(BLK_W'($urandom()), $urandom_range(10, 32), $urandom_range(0, 255));
      endcase
      refresh_pool();
      run_traffic(15, 1'b1);
    end
    drain_results();
  endtask

  task automatic test_back_to_back();
    configure(BLK_W'($urandom()), $urandom_range(20, 32), $urandom_range(0, 255));
    refresh_pool();
    run_traffic(20, 1'b0);
    drain_results();
  endtask

  // Compare each result with the oldest expectation
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: command %0h status %0h", result_o.command, result_o.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("command", 32'(want.command), 32'(result_o.command));
        check_field("source_block", 32'(want.source_block), 32'(result_o.source_block));
        check_field("target_block", 32'(want.target_block), 32'(result_o.target_block));
        check_field("device", 32'(want.device), 32'(result_o.device));
        check_field("header_count", 32'(want.header_count), 32'(result_o.header_count));
        check_field("status", 32'(want.status), 32'(result_o.status));
        check_field("newly_added", 32'(want.newly_added), 32'(result_o.newly_added));
        check_field("last", 32'(want.last), 32'(result_o.last));
      end
    end
  end

  // Stop a hung run: count cycles with no item and no result accepted
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((start === 1'b1 && busy === 1'b0) || result_valid_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    item_i           = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    shadow_log_start = LOG_START_RESET;
    shadow_capacity  = LOG_CAP_RESET;
    shadow_device    = DEVICE_RESET;
    table_count      = 0;
    open_ops         = 0;
    last_status      = ST_OK;
    ok_items         = 0;
    calm_left        = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    foreach (table_blocks[i]) table_blocks[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    test_idle_errors();
    test_admission_and_absorption();
    test_log_space_limits();
    test_full_table();
    test_random_traffic();
    test_back_to_back();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
